/* rtl/sorted_timer_queue_unit_defines.svh */
// Assertion macros shared by the timer queue RTL.
`ifndef SORTED_TIMER_QUEUE_UNIT_DEFINES_SVH
`define SORTED_TIMER_QUEUE_UNIT_DEFINES_SVH

// Checked on every rising edge of clk outside reset.
`define STQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define STQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/stq_pkg.sv */
// Package with payload types, codes and defaults for the sorted timer queue.
package stq_pkg;

  // Default sizes of the entry store.
  localparam int DEPTH_DEF     = 16;
  localparam int KEY_BITS_DEF  = 16;
  localparam int TIME_BITS_DEF = 32;

  // Operation codes of a request.
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // Status codes of a result.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // One request on the input channel.
  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        seq_key;
    logic signed [31:0] event_time;
  } stq_req_t;

  // One result on the output channel.
  typedef struct packed {
    logic [1:0]         status_code;
    logic               expired;
    logic [4:0]         entry_total;
    logic [15:0]        head_key;
    logic signed [31:0] head_time;
  } stq_rsp_t;

  // Outcome of the shared compare unit.
  typedef struct packed {
    logic key_eq;
    logic time_ge;
  } stq_cmp_t;

endpackage

/* rtl/stq_mem.sv */
// Entry store: one write port and one registered read port.
module stq_mem
  import stq_pkg::*;
#(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int ENTRY_W = KEY_BITS_DEF + TIME_BITS_DEF,
  localparam int IDX_W  = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem_r [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/stq_cmp.sv */
// Shared compare unit: key match and time order of a stored entry against the request.
module stq_cmp
  import stq_pkg::*;
#(
  parameter int KEY_BITS  = KEY_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic [KEY_BITS-1:0]  ent_key,
  input  logic [TIME_BITS-1:0] ent_time,
  input  logic [KEY_BITS-1:0]  req_key,
  input  logic [TIME_BITS-1:0] req_time,
  output stq_cmp_t             res
);

  // Times are two's complement, so the order is a signed compare.
  always_comb begin
    res.key_eq  = (ent_key == req_key);
    res.time_ge = ($signed(ent_time) >= $signed(req_time));
  end

endmodule

/* rtl/sorted_timer_queue_unit.sv */
// From accept to result valid the sequencer scans each stored entry, decides, reads the head and
// loads the result; entry moves, and for an insert that moves entries a place step, come before the head read.
// No new request is taken until the previous one has loaded its result; the single read port and compare unit set it.
// A new request is taken while the previous result still waits on out_stall.
// Reset clears the occupancy and the handshake state; the entry memory is not cleared.
`include "sorted_timer_queue_unit_defines.svh"

module sorted_timer_queue_unit
  import stq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_BITS  = KEY_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  stq_req_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output stq_rsp_t out_data
);

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = KEY_BITS + TIME_BITS;
  localparam logic [OCC_W-1:0] OCC_ONE   = OCC_W'(1);
  localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_TWO   = IDX_W'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE_UP,
    S_PLACE,
    S_MOVE_DN,
    S_HEAD,
    S_RESULT
  } state_t;

  state_t               state_r;
  logic [OCC_W-1:0]     occ_r;
  logic [1:0]           func_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [TIME_BITS-1:0] time_r;
  logic [IDX_W-1:0]     scan_r;
  logic [IDX_W-1:0]     ptr_r;
  logic                 found_r;
  logic [IDX_W-1:0]     hit_pos_r;
  logic                 ins_set_r;
  logic [OCC_W-1:0]     ins_pos_r;
  logic [1:0]           status_r;
  logic                 out_valid_r;
  stq_rsp_t             out_data_r;

  // Memory and compare unit connections.
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic [KEY_BITS-1:0]  rd_key;
  logic [TIME_BITS-1:0] rd_time;
  stq_cmp_t           cmp_res;

  // Width adaptation of the request and result fields.
  logic [KEY_BITS+15:0]  in_key_ext;
  logic [TIME_BITS+31:0] in_time_ext;
  logic [KEY_BITS+15:0]  head_key_ext;
  logic [TIME_BITS+31:0] head_time_ext;
  logic [OCC_W+4:0]      occ_ext;

  // Sequencer decisions.
  logic accept;
  logic out_free;
  logic load_result;
  logic scan_last;
  logic ins_ok;
  logic ins_append;
  logic del_last;
  logic up_last;
  logic dn_last;
  logic non_empty;

  assign in_key_ext  = {16'b0, in_data.seq_key};
  assign in_time_ext = {{TIME_BITS{in_data.event_time[31]}}, in_data.event_time};
  assign rd_key      = rd_data[ENTRY_W-1:TIME_BITS];
  assign rd_time     = rd_data[TIME_BITS-1:0];
  assign head_key_ext  = {16'b0, rd_key};
  assign head_time_ext = {32'b0, rd_time};
  assign occ_ext       = {5'b0, occ_r};

  assign accept      = in_valid && (state_r == S_IDLE);
  assign out_free    = !out_valid_r || !out_stall;
  assign load_result = (state_r == S_RESULT) && out_free;
  assign scan_last   = (OCC_W'(scan_r) + OCC_ONE) == occ_r;
  assign ins_ok      = !found_r && (occ_r != OCC_FULL);
  assign ins_append  = (ins_pos_r == occ_r);
  assign del_last    = (OCC_W'(hit_pos_r) + OCC_ONE) == occ_r;
  assign up_last     = (OCC_W'(ptr_r - IDX_ONE) == ins_pos_r);
  assign dn_last     = (OCC_W'(ptr_r) + OCC_ONE + OCC_ONE) == occ_r;
  assign non_empty   = (occ_r != '0);

  // Memory port control per sequencer step.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = {key_r, time_r};
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state_r)
      S_IDLE: begin
        rd_en = accept;
      end
      S_SCAN: begin
        rd_en   = !scan_last;
        rd_addr = scan_r + IDX_ONE;
      end
      S_DECIDE: begin
        if (func_r == FUNC_INSERT && ins_ok) begin
          if (ins_append) begin
            wr_en   = 1'b1;
            wr_addr = occ_r[IDX_W-1:0];
          end else begin
            rd_en   = 1'b1;
            rd_addr = occ_r[IDX_W-1:0] - IDX_ONE;
          end
        end else if (func_r == FUNC_CANCEL && found_r && !del_last) begin
          rd_en   = 1'b1;
          rd_addr = hit_pos_r + IDX_ONE;
        end
      end
      S_MOVE_UP: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_data;
        rd_en   = !up_last;
        rd_addr = ptr_r - IDX_TWO;
      end
      S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = ins_pos_r[IDX_W-1:0];
      end
      S_MOVE_DN: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_data;
        rd_en   = !dn_last;
        rd_addr = ptr_r + IDX_TWO;
      end
      S_HEAD: begin
        rd_en = 1'b1;
      end
      S_RESULT: begin
        rd_en = 1'b0;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Sequencer state, occupancy and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !load_result) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r    <= in_data.func;
            key_r     <= in_key_ext[KEY_BITS-1:0];
            time_r    <= in_time_ext[TIME_BITS-1:0];
            scan_r    <= '0;
            found_r   <= 1'b0;
            ins_set_r <= 1'b0;
            ins_pos_r <= occ_r;
            status_r  <= ST_OK;
            state_r   <= non_empty ? S_SCAN : S_DECIDE;
          end
        end
        // One stored entry per cycle through the compare unit.
        S_SCAN: begin
          if (cmp_res.key_eq && !found_r) begin
            found_r   <= 1'b1;
            hit_pos_r <= scan_r;
          end
          if (cmp_res.time_ge && !ins_set_r) begin
            ins_set_r <= 1'b1;
            ins_pos_r <= OCC_W'(scan_r);
          end
          scan_r <= scan_r + IDX_ONE;
          if (scan_last) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_r <= S_HEAD;
          unique case (func_r)
            FUNC_INSERT: begin
              if (found_r) begin
                status_r <= ST_DUPLICATE;
              end else if (occ_r == OCC_FULL) begin
                status_r <= ST_FULL;
              end else if (ins_append) begin
                occ_r <= occ_r + OCC_ONE;
              end else begin
                ptr_r   <= occ_r[IDX_W-1:0];
                state_r <= S_MOVE_UP;
              end
            end
            FUNC_CANCEL: begin
              if (!found_r) begin
                status_r <= ST_NOT_FOUND;
              end else if (del_last) begin
                occ_r <= occ_r - OCC_ONE;
              end else begin
                ptr_r   <= hit_pos_r;
                state_r <= S_MOVE_DN;
              end
            end
            default: begin
              status_r <= ST_OK;
            end
          endcase
        end
        // Shift entries one slot toward the tail to open the insert slot.
        S_MOVE_UP: begin
          ptr_r <= ptr_r - IDX_ONE;
          if (up_last) begin
            state_r <= S_PLACE;
          end
        end
        S_PLACE: begin
          occ_r   <= occ_r + OCC_ONE;
          state_r <= S_HEAD;
        end
        // Shift entries one slot toward the head over the cancelled one.
        S_MOVE_DN: begin
          ptr_r <= ptr_r + IDX_ONE;
          if (dn_last) begin
            occ_r   <= occ_r - OCC_ONE;
            state_r <= S_HEAD;
          end
        end
        S_HEAD: begin
          state_r <= S_RESULT;
        end
        // Load the result once the output register is free.
        S_RESULT: begin
          if (out_free) begin
            out_valid_r             <= 1'b1;
            out_data_r.status_code  <= status_r;
            out_data_r.entry_total  <= occ_ext[4:0];
            out_data_r.expired      <= non_empty &&
                                       (rd_time[TIME_BITS-1] || (rd_time == '0));
            out_data_r.head_key     <= non_empty ? head_key_ext[15:0] : 16'b0;
            out_data_r.head_time    <= non_empty ? head_time_ext[31:0] : 32'b0;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  stq_mem #(
    .DEPTH   (DEPTH),
    .ENTRY_W (ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stq_cmp #(
    .KEY_BITS  (KEY_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_cmp (
    .ent_key  (rd_key),
    .ent_time (rd_time),
    .req_key  (key_r),
    .req_time (time_r),
    .res      (cmp_res)
  );

  // The store never holds more than its depth.
  `STQ_ASSERT(a_occ_bound, occ_r <= OCC_FULL, "occupancy above depth")
  // A result only appears after the result step.
  `STQ_ASSERT(a_out_from_result, $rose(out_valid_r) |-> $past(state_r == S_RESULT),
              "result without result step")
  // Moving toward the tail never passes the insert slot.
  `STQ_ASSERT(a_move_up_bound, state_r == S_MOVE_UP |-> OCC_W'(ptr_r) > ins_pos_r,
              "move passed the insert slot")
  // Reset leaves the sequencer idle with no pending result.
  `STQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE) && !out_valid_r,
                     "not idle after reset")

endmodule

/* test/timer_queue_scoreboard_pkg.sv */
// Scoreboard class that predicts and checks every result of the sorted timer queue.
package timer_queue_scoreboard_pkg;
  import stq_pkg::*;

  localparam int QUEUE_DEPTH  = DEPTH_DEF;
  localparam int REPORT_LIMIT = 10;

  class timer_queue_scoreboard;
    // Shadow copy of the entry store, slot 0 is the head.
    logic [15:0]        key_slot[QUEUE_DEPTH];
    logic signed [31:0] time_slot[QUEUE_DEPTH];
    int                 held;
    stq_rsp_t           expected_q[$];
    int                 failures;

    function new();
      held     = 0;
      failures = 0;
    endfunction

    function int slot_of(logic [15:0] key);
      for (int i = 0; i < held; i++) begin
        if (key_slot[i] == key) return i;
      end
      return -1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted request to the shadow store and queue up its result.
    function void note_request(stq_req_t req);
      stq_rsp_t rsp;
      int       slot;
      int       at;
      rsp = '0;
      rsp.status_code = ST_OK;
      slot = slot_of(req.seq_key);
      case (req.func)
        FUNC_INSERT: begin
          // The duplicate check wins over the full check.
          if (slot >= 0) begin
            rsp.status_code = ST_DUPLICATE;
          end else if (held >= QUEUE_DEPTH) begin
            rsp.status_code = ST_FULL;
          end else begin
            // New entry goes in front of the first entry that is not earlier.
            at = held;
            for (int i = 0; i < held; i++) begin
              if ($signed(time_slot[i]) >= $signed(req.event_time)) begin
                at = i;
                break;
              end
            end
            for (int i = held; i > at; i--) begin
              key_slot[i]  = key_slot[i - 1];
              time_slot[i] = time_slot[i - 1];
            end
            key_slot[at]  = req.seq_key;
            time_slot[at] = req.event_time;
            held++;
          end
        end
        FUNC_CANCEL: begin
          if (slot < 0) begin
            rsp.status_code = ST_NOT_FOUND;
          end else begin
            for (int i = slot; i + 1 < held; i++) begin
              key_slot[i]  = key_slot[i + 1];
              time_slot[i] = time_slot[i + 1];
            end
            held--;
          end
        end
        default: begin
          // Query and the unused code only report the head.
        end
      endcase
      rsp.entry_total = held[4:0];
      if (held > 0) begin
        rsp.expired   = ($signed(time_slot[0]) <= 0);
        rsp.head_key  = key_slot[0];
        rsp.head_time = time_slot[0];
      end
      expected_q.push_back(rsp);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(stq_rsp_t got);
      stq_rsp_t exp_rsp;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result with no request waiting: status %0d total %0d",
                   got.status_code, got.entry_total);
        return;
      end
      exp_rsp = expected_q.pop_front();
      if (got.status_code !== exp_rsp.status_code || got.expired !== exp_rsp.expired ||
          got.entry_total !== exp_rsp.entry_total || got.head_key !== exp_rsp.head_key ||
          got.head_time !== exp_rsp.head_time) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("mismatch: expected status %0d expired %0d total %0d key %h time %0d",
                   exp_rsp.status_code, exp_rsp.expired, exp_rsp.entry_total,
                   exp_rsp.head_key, $signed(exp_rsp.head_time));
          $display("          actual   status %0d expired %0d total %0d key %h time %0d",
                   got.status_code, got.expired, got.entry_total,
                   got.head_key, $signed(got.head_time));
        end
      end
    endfunction
  endclass

endpackage

/* test/testbench.sv */
// Top-level testbench that drives requests into the sorted timer queue and checks its results.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stq_pkg::*;
  import timer_queue_scoreboard_pkg::*;

  localparam logic [1:0]         FUNC_UNUSED  = 2'd3;
  localparam logic signed [31:0] TIME_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] TIME_MAX     = 32'sh7FFF_FFFF;
  localparam int                 RANDOM_ITEMS = 530;
  localparam int                 QUIET_ITEMS  = 60;
  localparam int                 TAIL_CYCLES  = 40;
  localparam int                 IDLE_LIMIT   = 2000;

  typedef enum logic [1:0] {FILL_UP, DRAIN_OUT, MIX_OPS} phase_mode_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  stq_req_t in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  stq_rsp_t out_data;

  timer_queue_scoreboard sb = new();

  int          gap_pct   = 0;
  int          stall_pct = 0;
  int          sent_total = 0;
  int          idle_cycles = 0;
  logic [15:0] key_base  = '0;

  sorted_timer_queue_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Every result taken from the block is checked against the prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Watchdog on cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver stalls come in bursts of random length.
  initial begin : receiver_stalls
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Drive one request, possibly after an idle burst, and note it once accepted.
  task automatic send_request(input logic [1:0] func, input logic [15:0] key,
                              input logic signed [31:0] event_time);
    stq_req_t req;
    req.func       = func;
    req.seq_key    = key;
    req.event_time = event_time;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    sent_total++;
  endtask

  // Hold off new requests until every predicted result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic signed [31:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return TIME_MIN;
      1:       return TIME_MAX;
      2:       return 32'sd0;
      3:       return $signed($urandom_range(0, 16)) - 8;
      4:       return (sb.held > 0) ? sb.time_slot[$urandom_range(0, sb.held - 1)] : 32'sd0;
      5, 6:    return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  // Keys come from a small pool per phase, so duplicates and hits are common.
  function automatic logic [15:0] pool_key();
    return key_base ^ 16'($urandom_range(0, 31));
  endfunction

  function automatic logic [15:0] held_key();
    return sb.key_slot[$urandom_range(0, sb.held - 1)];
  endfunction

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      send_request(FUNC_INSERT,
                   (sb.held > 0 && $urandom_range(0, 6) == 0) ? held_key() : pool_key(),
                   pick_time());
    else if (r < 80)
      send_request(FUNC_CANCEL,
                   (sb.held > 0 && $urandom_range(0, 3) != 0) ? held_key() : pool_key(),
                   pick_time());
    else if (r < 95)
      send_request(FUNC_QUERY, 16'($urandom), $urandom);
    else
      send_request(FUNC_UNUSED, 16'($urandom), $urandom);
  endtask

  function automatic int pick_rate();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      default: return 30;
    endcase
  endfunction

  initial begin : stimulus
    phase_mode_t mode;
    int          phase;
    int          start_count;
    int          span;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty queue, extremes, ties at head and behind it.
    gap_pct   = 20;
    stall_pct = 20;
    send_request(FUNC_QUERY,  16'h0000, 32'sd0);
    send_request(FUNC_CANCEL, 16'h0005, 32'sd0);
    send_request(FUNC_UNUSED, 16'hFFFF, TIME_MAX);
    send_request(FUNC_INSERT, 16'h0000, 32'sd0);
    send_request(FUNC_INSERT, 16'hFFFF, TIME_MAX);
    send_request(FUNC_INSERT, 16'h0001, TIME_MIN);
    send_request(FUNC_INSERT, 16'h0000, 32'sd5);
    send_request(FUNC_INSERT, 16'h0002, 32'sd0);
    send_request(FUNC_INSERT, 16'h0003, TIME_MIN);
    send_request(FUNC_INSERT, 16'h0004, 32'sd100);
    send_request(FUNC_QUERY,  16'h0000, 32'sd0);
    send_request(FUNC_CANCEL, 16'h0003, 32'sd0);
    send_request(FUNC_CANCEL, 16'hFFFF, 32'sd0);
    send_request(FUNC_CANCEL, 16'h0077, 32'sd0);
    send_request(FUNC_CANCEL, 16'h0001, 32'sd0);
    send_request(FUNC_CANCEL, 16'h0002, 32'sd0);
    send_request(FUNC_CANCEL, 16'h0000, 32'sd0);
    send_request(FUNC_INSERT, 16'h0005, -32'sd1);
    send_request(FUNC_CANCEL, 16'h0004, 32'sd0);
    send_request(FUNC_CANCEL, 16'h0005, 32'sd0);
    wait_for_results();

    // Random part in phases; the first one fills the queue to its limit.
    start_count = sent_total;
    phase = 0;
    while (sent_total - start_count < RANDOM_ITEMS) begin
      if (RANDOM_ITEMS - (sent_total - start_count) <= QUIET_ITEMS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = pick_rate();
        stall_pct = pick_rate();
      end
      key_base = 16'($urandom);
      mode = (phase == 0) ? FILL_UP : phase_mode_t'($urandom_range(0, 2));
      case (mode)
        FILL_UP: begin
          while (sb.held < QUEUE_DEPTH) send_request(FUNC_INSERT, pool_key(), pick_time());
          // Inserts into a full queue, some with keys already held.
          repeat (3) begin
            send_request(FUNC_INSERT,
                         $urandom_range(0, 1) ? held_key() : 16'($urandom), pick_time());
          end
        end
        DRAIN_OUT: begin
          while (sb.held > 0) begin
            if ($urandom_range(0, 5) == 0) random_request();
            else send_request(FUNC_CANCEL, held_key(), pick_time());
          end
        end
        default: begin
          span = $urandom_range(20, 60);
          repeat (span) random_request();
        end
      endcase
      phase++;
      // No pauses once the closing stretch without idling has begun.
      if (phase == 1 ||
          (RANDOM_ITEMS - (sent_total - start_count) > QUIET_ITEMS &&
           $urandom_range(0, 3) == 0)) begin
        wait_for_results();
      end
    end

    // Let the last results and any stray extra result arrive.
    stall_pct = 0;
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/stq_pkg.sv
rtl/stq_mem.sv
rtl/stq_cmp.sv
rtl/sorted_timer_queue_unit.sv
test/timer_queue_scoreboard_pkg.sv
test/testbench.sv
